FILE: hw/rtl/gtt_pkg.sv
// Shared types and constants for the gas resistance trend tracker.
package gtt_pkg;

  // Field widths
  localparam int unsigned TimeW  = 32;
  localparam int unsigned GasW   = 24;
  localparam int unsigned DeltaW = 25;
  localparam int unsigned TrendW = 2;

  // Configuration register indexes
  localparam int unsigned CfgIdxW = 2;
  localparam logic [CfgIdxW-1:0] CFG_PUSH_INTERVAL = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_TREND_WINDOW  = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_STABLE_BAND   = 2'd2;

  // Trend codes (two's complement)
  localparam logic [TrendW-1:0] TREND_FLAT = 2'b00;
  localparam logic [TrendW-1:0] TREND_UP   = 2'b01;
  localparam logic [TrendW-1:0] TREND_DOWN = 2'b11;

  // One history ring entry
  typedef struct packed {
    logic [TimeW-1:0] stamp;
    logic [GasW-1:0]  gas;
  } hist_entry_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CHECK,
    ST_WALK,
    ST_DELTA,
    ST_FINISH
  } seq_state_e;

endpackage

FILE: hw/rtl/gtt_hist.sv
// History ring memory: one write port, one registered read port.
module gtt_hist
  import gtt_pkg::*;
#(
  parameter int unsigned Depth = 16,
  parameter int unsigned AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  hist_entry_t      wr_data_i,
  input  logic             rd_en_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output hist_entry_t      rd_data_o
);

  hist_entry_t mem_q [Depth];
  hist_entry_t rd_data_q;

  // Write port
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem_q[wr_addr_i] <= wr_data_i;
    end
  end

  // Registered read port
  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem_q[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: hw/rtl/gtt_alu.sv
// Shared subtract-and-compare unit: diff = a - b modulo 2^32, ge = diff >= thr.
module gtt_alu
  import gtt_pkg::*;
(
  input  logic [TimeW-1:0] op_a_i,
  input  logic [TimeW-1:0] op_b_i,
  input  logic [TimeW-1:0] thr_i,
  output logic [TimeW-1:0] diff_o,
  output logic             ge_o
);

  // Wrap-around difference, then unsigned compare against threshold
  assign diff_o = op_a_i - op_b_i;
  assign ge_o   = (diff_o >= thr_i);

endmodule

FILE: hw/rtl/gas_resistance_trend_tracker.sv
// Top level: config registers, sequencer, history ring walk and result register.
//
//  Channel   | Signals                          | Word contents (low bit first)
//  ----------+----------------------------------+-----------------------------------------
//  s_axis    | tvalid, tready, tdata[55:0]      | now_ms[31:0], gas_reading[23:0]
//  m_axis    | tvalid, tready, tdata[31:0],tuser| gas_delta[24:0], trend[1:0], pad; tuser: found
//  cfg       | valid, ready, index[1:0], data   | 0 push_interval_ms, 1 trend_window_ms, 2 band
//
// A dropped word (zero reading or interval not elapsed) goes from the check state back to idle.
// A pushed word walks k entries, k = 1..HISTORY_DEPTH, newest to oldest, since the
// ring memory gives one registered read per cycle; the delta and finish states follow.
// Reset sets the config and control registers to defaults and the ring to empty; no clearing pass.
// s_axis_tready_o is high only while idle; a result waits in the output register
// and a new word is accepted meanwhile; a finished result stalls until that register frees.
module gas_resistance_trend_tracker
  import gtt_pkg::*;
#(
  parameter int unsigned HISTORY_DEPTH = 16
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  // Input stream: now_ms[31:0], gas_reading[55:32]
  input  logic                  s_axis_tvalid_i,
  output logic                  s_axis_tready_o,
  input  logic [55:0]           s_axis_tdata_i,
  // Output stream: gas_delta[24:0], trend[26:25], zero pad [31:27]
  output logic                  m_axis_tvalid_o,
  input  logic                  m_axis_tready_i,
  output logic [31:0]           m_axis_tdata_o,
  // Output flag: baseline_found[0]
  output logic                  m_axis_tuser_o,
  // Configuration write channel
  input  logic                  cfg_valid_i,
  output logic                  cfg_ready_o,
  input  logic [CfgIdxW-1:0]    cfg_index_i,
  input  logic [31:0]           cfg_data_i
);

  localparam int unsigned AddrW = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
  localparam int unsigned CntW  = $clog2(HISTORY_DEPTH + 1);
  localparam logic [AddrW-1:0] LastAddr = AddrW'(HISTORY_DEPTH - 1);
  localparam logic [CntW-1:0]  FullCnt  = CntW'(HISTORY_DEPTH);

  // Configuration registers
  logic [TimeW-1:0] push_ivl_q;
  logic [TimeW-1:0] window_q;
  logic [GasW-1:0]  band_q;

  // Sequencer and ring state
  seq_state_e       state_q, state_d;
  logic [AddrW-1:0] head_q, head_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [TimeW-1:0] last_push_q, last_push_d;
  logic [AddrW-1:0] ptr_q, ptr_d;
  logic [CntW-1:0]  rd_cnt_q, rd_cnt_d;
  logic             cmp_vld_q, cmp_vld_d;
  logic             found_q, found_d;

  // Item payload
  logic [TimeW-1:0]  now_q, now_d;
  logic [GasW-1:0]   gas_q, gas_d;
  logic [GasW-1:0]   base_q, base_d;
  logic [DeltaW-1:0] delta_q, delta_d;

  // Output register
  logic              out_vld_q, out_vld_d;
  logic [DeltaW-1:0] out_delta_q, out_delta_d;
  logic [TrendW-1:0] out_trend_q, out_trend_d;
  logic              out_found_q, out_found_d;

  // Memory and shared unit hookup
  logic             mem_we, mem_re;
  hist_entry_t      mem_wdata, mem_rdata;
  logic [TimeW-1:0] alu_a, alu_b, alu_thr, alu_diff;
  logic             alu_ge;

  logic             out_free;
  logic             in_acc;
  logic [TrendW-1:0] trend_val;

  assign cfg_ready_o     = 1'b1;
  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_acc          = s_axis_tvalid_i & s_axis_tready_o;
  assign out_free        = ~out_vld_q | m_axis_tready_i;

  assign m_axis_tvalid_o = out_vld_q;
  assign m_axis_tdata_o  = {5'd0, out_trend_q, out_delta_q};
  assign m_axis_tuser_o  = out_found_q;

  gtt_hist #(
    .Depth (HISTORY_DEPTH),
    .AddrW (AddrW)
  ) u_hist (
    .clk_i     (clk_i),
    .wr_en_i   (mem_we),
    .wr_addr_i (head_q),
    .wr_data_i (mem_wdata),
    .rd_en_i   (mem_re),
    .rd_addr_i (ptr_q),
    .rd_data_o (mem_rdata)
  );

  gtt_alu u_alu (
    .op_a_i (alu_a),
    .op_b_i (alu_b),
    .thr_i  (alu_thr),
    .diff_o (alu_diff),
    .ge_o   (alu_ge)
  );

  // Write configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      push_ivl_q <= 32'd120000;
      window_q   <= 32'd300000;
      band_q     <= 24'd90;
    end else if (cfg_valid_i && cfg_ready_o) begin
      case (cfg_index_i)
        CFG_PUSH_INTERVAL: push_ivl_q <= cfg_data_i;
        CFG_TREND_WINDOW:  window_q   <= cfg_data_i;
        CFG_STABLE_BAND:   band_q     <= cfg_data_i[GasW-1:0];
        default: ;
      endcase
    end
  end

  // Hold control state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      head_q      <= '0;
      cnt_q       <= '0;
      last_push_q <= '0;
      cmp_vld_q   <= 1'b0;
      out_vld_q   <= 1'b0;
    end else begin
      state_q     <= state_d;
      head_q      <= head_d;
      cnt_q       <= cnt_d;
      last_push_q <= last_push_d;
      cmp_vld_q   <= cmp_vld_d;
      out_vld_q   <= out_vld_d;
    end
  end

  // Hold payload
  always_ff @(posedge clk_i) begin
    ptr_q       <= ptr_d;
    rd_cnt_q    <= rd_cnt_d;
    found_q     <= found_d;
    now_q       <= now_d;
    gas_q       <= gas_d;
    base_q      <= base_d;
    delta_q     <= delta_d;
    out_delta_q <= out_delta_d;
    out_trend_q <= out_trend_d;
    out_found_q <= out_found_d;
  end

  // Trend against the dead band
  always_comb begin
    trend_val = TREND_FLAT;
    if ($signed(delta_q) > $signed({1'b0, band_q})) begin
      trend_val = TREND_UP;
    end else if ($signed(delta_q) < -$signed({1'b0, band_q})) begin
      trend_val = TREND_DOWN;
    end
  end

  // Sequencer: next state, shared unit operands, memory control
  always_comb begin
    state_d     = state_q;
    head_d      = head_q;
    cnt_d       = cnt_q;
    last_push_d = last_push_q;
    ptr_d       = ptr_q;
    rd_cnt_d    = rd_cnt_q;
    cmp_vld_d   = 1'b0;
    found_d     = found_q;
    now_d       = now_q;
    gas_d       = gas_q;
    base_d      = base_q;
    delta_d     = delta_q;
    out_vld_d   = out_vld_q & ~m_axis_tready_i;
    out_delta_d = out_delta_q;
    out_trend_d = out_trend_q;
    out_found_d = out_found_q;
    mem_we      = 1'b0;
    mem_re      = 1'b0;
    mem_wdata   = '{stamp: now_q, gas: gas_q};
    alu_a       = now_q;
    alu_b       = last_push_q;
    alu_thr     = push_ivl_q;

    case (state_q)
      ST_IDLE: begin
        // Take a new word
        if (in_acc) begin
          now_d   = s_axis_tdata_i[TimeW-1:0];
          gas_d   = s_axis_tdata_i[TimeW +: GasW];
          state_d = ST_CHECK;
        end
      end

      ST_CHECK: begin
        // Drop invalid readings and pushes inside the interval
        if (gas_q == '0) begin
          state_d = ST_IDLE;
        end else if (last_push_q != '0 && !alu_ge) begin
          state_d = ST_IDLE;
        end else begin
          mem_we      = 1'b1;
          last_push_d = now_q;
          head_d      = (head_q == LastAddr) ? '0 : head_q + 1'b1;
          if (cnt_q != FullCnt) begin
            cnt_d = cnt_q + 1'b1;
          end
          ptr_d    = head_q;
          rd_cnt_d = '0;
          found_d  = 1'b0;
          state_d  = ST_WALK;
        end
      end

      ST_WALK: begin
        // Issue one read per cycle, newest to oldest
        alu_b   = mem_rdata.stamp;
        alu_thr = window_q;
        if (rd_cnt_q != cnt_q) begin
          mem_re    = 1'b1;
          ptr_d     = (ptr_q == '0) ? LastAddr : ptr_q - 1'b1;
          rd_cnt_d  = rd_cnt_q + 1'b1;
          cmp_vld_d = 1'b1;
        end
        // Check the entry read last cycle
        if (cmp_vld_q) begin
          if (alu_ge) begin
            found_d   = 1'b1;
            base_d    = mem_rdata.gas;
            cmp_vld_d = 1'b0;
            state_d   = ST_DELTA;
          end else if (rd_cnt_q == cnt_q) begin
            state_d = ST_DELTA;
          end
        end
      end

      ST_DELTA: begin
        // Signed difference through the shared unit
        alu_a   = {{(TimeW-GasW){1'b0}}, gas_q};
        alu_b   = {{(TimeW-GasW){1'b0}}, base_q};
        alu_thr = '0;
        delta_d = found_q ? alu_diff[DeltaW-1:0] : '0;
        state_d = ST_FINISH;
      end

      ST_FINISH: begin
        // Load the output register once it frees
        if (out_free) begin
          out_vld_d   = 1'b1;
          out_delta_d = delta_q;
          out_trend_d = trend_val;
          out_found_d = found_q;
          state_d     = ST_IDLE;
        end
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

FILE: tb/sv/testbench.sv
// Self-checking stream testbench for the gas resistance trend tracker.
module testbench;
  import gtt_pkg::*;

  localparam int unsigned RingDepth    = 16;
  localparam int unsigned SettleCycles = 32;
  localparam int unsigned StallLimit   = 2000;
  localparam int unsigned TargetItems  = 650;
  localparam int unsigned PhaseItems   = 50;
  localparam int unsigned MaxPhases    = 60;
  localparam int unsigned MaxGap       = 16;
  localparam logic [CfgIdxW-1:0] CFG_UNUSED = 2'd3;

  // One result word, split into its fields
  typedef struct packed {
    logic [DeltaW-1:0] delta;
    logic [TrendW-1:0] trend;
    logic              found;
  } trend_word_t;

  typedef enum logic {ROW_READING, ROW_REG} row_kind_e;

  // One directed step: a reading to send or a register to write
  typedef struct {
    row_kind_e          kind;
    logic [TimeW-1:0]   value;  // now_ms, or register data
    logic [GasW-1:0]    gas;
    logic [CfgIdxW-1:0] index;
    bit                 known;  // result typed in below instead of predicted
    trend_word_t        want;
  } stim_row_t;

  logic               clk_i;
  logic               rst_ni;
  logic               s_tvalid;
  logic               s_tready;
  logic [55:0]        s_tdata;
  logic               m_tvalid;
  logic               m_tready;
  logic [31:0]        m_tdata;
  logic               m_tuser;
  logic               cfg_valid;
  logic               cfg_ready;
  logic [CfgIdxW-1:0] cfg_index;
  logic [31:0]        cfg_data;

  // Predictor copy of the registers and the history ring
  logic [TimeW-1:0] push_interval = 32'd120000;
  logic [TimeW-1:0] trend_window  = 32'd300000;
  logic [GasW-1:0]  stable_band   = 24'd90;
  logic [TimeW-1:0] ring_stamp [RingDepth];
  logic [GasW-1:0]  ring_gas   [RingDepth];
  int unsigned      ring_head   = 0;
  int unsigned      ring_count  = 0;
  logic [TimeW-1:0] last_push   = '0;

  trend_word_t pending_trends [$];
  int unsigned mismatch_count = 0;
  int unsigned item_count     = 0;
  int unsigned idle_cycles    = 0;
  bit          cur_known;
  trend_word_t cur_want;
  bit          tx_steady;
  bit          rx_steady;

  gas_resistance_trend_tracker #(
    .HISTORY_DEPTH(RingDepth)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_tvalid),
    .s_axis_tready_o(s_tready),
    .s_axis_tdata_i (s_tdata),
    .m_axis_tvalid_o(m_tvalid),
    .m_axis_tready_i(m_tready),
    .m_axis_tdata_o (m_tdata),
    .m_axis_tuser_o (m_tuser),
    .cfg_valid_i    (cfg_valid),
    .cfg_ready_o    (cfg_ready),
    .cfg_index_i    (cfg_index),
    .cfg_data_i     (cfg_data)
  );

  initial begin
    clk_i = 1'b0;
    forever #4 clk_i = ~clk_i;
  end

  // Advance the ring on a reading; return 1 when the reading is pushed
  function automatic bit predict_trend(input logic [TimeW-1:0] now, input logic [GasW-1:0] gas,
                                       output trend_word_t res);
    logic [TimeW-1:0]        age;
    logic [GasW-1:0]         base;
    logic signed [GasW+1:0]  diff;
    logic signed [GasW+1:0]  lim;
    int unsigned             slot;
    int unsigned             walk;
    bit                      hit;
    res  = '0;
    hit  = 1'b0;
    base = '0;
    age  = now - last_push;
    if (gas == '0) return 1'b0;
    if (last_push != '0 && age < push_interval) return 1'b0;
    last_push = now;
    ring_stamp[ring_head] = now;
    ring_gas[ring_head]   = gas;
    ring_head = (ring_head + 1) % RingDepth;
    if (ring_count < RingDepth) ring_count++;
    // Walk newest to oldest; take the first entry old enough
    for (walk = 0; walk < ring_count && !hit; walk++) begin
      slot = (ring_head + RingDepth - 1 - walk) % RingDepth;
      age  = now - ring_stamp[slot];
      if (age >= trend_window) begin
        base = ring_gas[slot];
        hit  = 1'b1;
      end
    end
    if (hit) begin
      diff = $signed({2'b00, gas}) - $signed({2'b00, base});
      lim  = $signed({2'b00, stable_band});
      res.delta = diff[DeltaW-1:0];
      res.found = 1'b1;
      if (diff > lim) res.trend = TREND_UP;
      else if (diff < -lim) res.trend = TREND_DOWN;
      else res.trend = TREND_FLAT;
    end
    return 1'b1;
  endfunction

  function automatic void note_mismatch(input string what, input logic [31:0] want,
                                        input logic [31:0] got);
    mismatch_count++;
    if (mismatch_count <= 10) begin
      $display("mismatch on %s: expected %0h, got %0h", what, want, got);
    end
  endfunction

  function automatic stim_row_t reading_row(input logic [TimeW-1:0] now,
                                            input logic [GasW-1:0] gas);
    stim_row_t row;
    row.kind  = ROW_READING;
    row.value = now;
    row.gas   = gas;
    row.index = CFG_PUSH_INTERVAL;
    row.known = 1'b0;
    row.want  = '0;
    return row;
  endfunction

  function automatic stim_row_t known_row(input logic [TimeW-1:0] now, input logic [GasW-1:0] gas,
                                          input logic [DeltaW-1:0] delta,
                                          input logic [TrendW-1:0] trend, input logic found);
    stim_row_t row;
    row = reading_row(now, gas);
    row.known      = 1'b1;
    row.want.delta = delta;
    row.want.trend = trend;
    row.want.found = found;
    return row;
  endfunction

  function automatic stim_row_t reg_row(input logic [CfgIdxW-1:0] index,
                                        input logic [31:0] data);
    stim_row_t row;
    row = reading_row('0, '0);
    row.kind  = ROW_REG;
    row.index = index;
    row.value = data;
    return row;
  endfunction

  // Send one reading word after an idle gap; return at the falling edge after acceptance
  task automatic send_reading(input logic [TimeW-1:0] now, input logic [GasW-1:0] gas,
                              input bit known, input trend_word_t want, input int unsigned gap);
    if (gap != 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    cur_known = known;
    cur_want  = want;
    s_tvalid <= 1'b1;
    s_tdata  <= {gas, now};
    do @(posedge clk_i); while (!s_tready);
    @(negedge clk_i);
  endtask

  // Hold the sender until every result is in and the block has gone quiet
  task automatic settle();
    s_tvalid <= 1'b0;
    while (pending_trends.size() != 0) @(negedge clk_i);
    repeat (SettleCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CfgIdxW-1:0] index, input logic [31:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= index;
    cfg_data  <= data;
    do @(posedge clk_i); while (!cfg_ready);
    @(negedge clk_i);
    cfg_valid <= 1'b0;
    @(negedge clk_i);
  endtask

  // Check result words, predict on accepted readings, track register writes
  always @(posedge clk_i) begin
    trend_word_t seen;
    trend_word_t want;
    if (rst_ni) begin
      if (m_tvalid && m_tready) begin
        seen.delta = m_tdata[DeltaW-1:0];
        seen.trend = m_tdata[DeltaW +: TrendW];
        seen.found = m_tuser;
        if (pending_trends.size() == 0) begin
          note_mismatch("unexpected result word", '0, 32'(seen));
        end else begin
          want = pending_trends.pop_front();
          if (seen.delta !== want.delta) begin
            note_mismatch("gas_delta", 32'(want.delta), 32'(seen.delta));
          end
          if (seen.trend !== want.trend) begin
            note_mismatch("trend", 32'(want.trend), 32'(seen.trend));
          end
          if (seen.found !== want.found) begin
            note_mismatch("baseline_found", 32'(want.found), 32'(seen.found));
          end
        end
      end
      if (s_tvalid && s_tready) begin
        item_count++;
        if (predict_trend(s_tdata[TimeW-1:0], s_tdata[TimeW +: GasW], want)) begin
          pending_trends.push_back(cur_known ? cur_want : want);
        end
      end
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_PUSH_INTERVAL: push_interval = cfg_data;
          CFG_TREND_WINDOW:  trend_window  = cfg_data;
          CFG_STABLE_BAND:   stable_band   = cfg_data[GasW-1:0];
          default: ;
        endcase
      end
      if ((m_tvalid && m_tready) || (s_tvalid && s_tready) || (cfg_valid && cfg_ready)) begin
        idle_cycles = 0;
      end else begin
        idle_cycles++;
      end
    end
  end

  // Result sink: unless rx_steady is set, stall a random number of cycles before taking each word
  initial begin : result_sink
    int unsigned stall;
    m_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      stall = rx_steady ? 0 : $urandom_range(0, MaxGap);
      if (stall != 0) begin
        m_tready <= 1'b0;
        repeat (stall) @(negedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!m_tvalid);
      @(negedge clk_i);
    end
  end

  initial begin : watchdog
    while (idle_cycles < StallLimit) @(posedge clk_i);
    $display("Mismatches found");
    $finish;
  end

  initial begin : stimulus
    stim_row_t        rows [$];
    logic [TimeW-1:0] now;
    logic [TimeW-1:0] interval;
    logic [TimeW-1:0] window;
    logic [31:0]      band;
    logic [TimeW-1:0] span;
    logic [GasW-1:0]  gas;
    int               level;
    int unsigned      phase;
    int unsigned      n;
    int unsigned      mode;
    int unsigned      pick;
    int unsigned      gap;
    rst_ni    = 1'b0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    cfg_valid = 1'b0;
    cfg_index = CFG_PUSH_INTERVAL;
    cfg_data  = '0;
    cur_known = 1'b0;
    cur_want  = '0;
    tx_steady = 1'b0;
    rx_steady = 1'b0;

    // Directed part, starting from the reset register values
    rows.push_back(reading_row(32'd1000, 24'h000000));                  // invalid reading
    rows.push_back(known_row(32'd1000, 24'h000100, '0, TREND_FLAT, 1'b0)); // first push
    rows.push_back(reading_row(32'd2000, 24'h000200));                  // interval not elapsed
    rows.push_back(known_row(32'd121000, 24'h000300, '0, TREND_FLAT, 1'b0));
    rows.push_back(reading_row(32'd301000, 24'h000400));                // baseline, rising
    rows.push_back(reg_row(CFG_TREND_WINDOW, 32'd0));
    rows.push_back(known_row(32'd500000, 24'h000123, '0, TREND_FLAT, 1'b1)); // zero window
    rows.push_back(reg_row(CFG_PUSH_INTERVAL, 32'd0));
    rows.push_back(reg_row(CFG_TREND_WINDOW, 32'hFFFF_FFFF));
    rows.push_back(reg_row(CFG_STABLE_BAND, 32'd0));
    rows.push_back(known_row(32'd600000, 24'hFFFFFF, '0, TREND_FLAT, 1'b0));
    rows.push_back(reading_row(32'd599999, 24'h000001));                // full age, deepest fall
    rows.push_back(reading_row(32'd0, 24'h000005));                     // push at time zero
    rows.push_back(reg_row(CFG_PUSH_INTERVAL, 32'hFFFF_FFFF));
    rows.push_back(reading_row(32'd10, 24'h000006));                    // reads as never pushed
    rows.push_back(reading_row(32'd20, 24'h000007));
    rows.push_back(reading_row(32'd9, 24'h000008));                     // elapsed wraps to max
    rows.push_back(reg_row(CFG_STABLE_BAND, 32'hFFFF_FFFF));
    rows.push_back(reg_row(CFG_PUSH_INTERVAL, 32'd1));
    rows.push_back(reg_row(CFG_TREND_WINDOW, 32'd1));
    rows.push_back(reading_row(32'd100, 24'hFFFFFF));
    rows.push_back(reg_row(CFG_UNUSED, 32'd0));                         // unknown index, ignored
    rows.push_back(reading_row(32'd200, 24'h000001));
    rows.push_back(reg_row(CFG_STABLE_BAND, 32'h0000_0080));
    rows.push_back(reading_row(32'd300, 24'hFFFFFF));

    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_REG) begin
        settle();
        write_reg(rows[i].index, rows[i].value);
      end else begin
        send_reading(rows[i].value, rows[i].gas, rows[i].known, rows[i].want,
                     $urandom_range(0, MaxGap));
      end
    end

    // Random phases, each with its own register setting and time scale
    now   = 32'd1000;
    level = 32'h800;
    for (phase = 0; phase < MaxPhases && item_count < TargetItems; phase++) begin
      settle();
      mode = $urandom_range(0, 5);
      case (mode)
        0, 1, 2: begin
          interval = $urandom_range(0, 12);
          window   = $urandom_range(0, 60);
          span     = 2 * interval + 6;
        end
        3: begin
          interval = 32'd120000;
          window   = 32'd300000;
          span     = 32'd250000;
        end
        4: begin
          interval = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
          window   = $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
          span     = 32'd20;
        end
        default: begin
          interval = $urandom;
          window   = $urandom;
          span     = 32'hFFFF_FFFF;
        end
      endcase
      case ($urandom_range(0, 4))
        0:       band = 32'd0;
        1:       band = $urandom;
        2:       band = 32'h00FF_FFFF;
        default: band = $urandom_range(0, 600);
      endcase
      write_reg(CFG_PUSH_INTERVAL, interval);
      write_reg(CFG_TREND_WINDOW, window);
      write_reg(CFG_STABLE_BAND, band);
      if ($urandom_range(0, 3) == 0) write_reg(CFG_UNUSED, $urandom);
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_steady = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 3))
        0:       now = $urandom;
        1:       now = 32'hFFFF_FFFF - $urandom_range(0, 40);
        default: ;
      endcase

      for (n = 0; n < PhaseItems; n++) begin
        // Advance time, with the odd jump and step back
        pick = $urandom_range(0, 99);
        if (pick < 4) now = $urandom;
        else if (pick < 9) now = now - 1;
        else now = now + ((span == 32'hFFFF_FFFF) ? $urandom : $urandom_range(0, span));
        // Drift the reading, with the odd extreme or invalid value
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          gas = '0;
        end else if (pick < 12) begin
          gas   = $urandom_range(0, 1) ? 24'hFFFFFF : 24'h000001;
          level = int'(gas);
        end else if (pick < 40) begin
          gas   = GasW'($urandom_range(1, 24'hFFFFFF));
          level = int'(gas);
        end else begin
          level = level + int'($urandom_range(0, 800)) - 400;
          if (level < 1) level = 1;
          if (level > 32'hFF_FFFF) level = 32'hFF_FFFF;
          gas = level[GasW-1:0];
        end
        gap = tx_steady ? 0 : $urandom_range(0, MaxGap);
        send_reading(now, gas, 1'b0, '0, gap);
        if ($urandom_range(0, 49) == 0) settle();
      end
    end

    settle();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule

FILE: gas_resistance_trend_tracker.f
hw/rtl/gtt_pkg.sv
hw/rtl/gtt_hist.sv
hw/rtl/gtt_alu.sv
hw/rtl/gas_resistance_trend_tracker.sv
tb/sv/testbench.sv
